/* rtl/core/pbc_pkg.sv */
package pbc_pkg;

  // Field widths fixed by the descriptor format
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned BYTES_W  = 22;
  localparam int unsigned TICKS_W  = 24;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DEPTH_DEFAULT = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP         = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PARSE_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PARSE_NEXT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PARSE_STOP  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd6;

  // Status query codes
  localparam logic [1:0] STAT_NOT_READY = 2'd0;
  localparam logic [1:0] STAT_READY     = 2'd1;
  localparam logic [1:0] STAT_FLUSHED   = 2'd2;
  localparam logic [1:0] STAT_START_BUF = 2'd3;

  // Slow mode levels
  localparam logic [1:0] SLOW_OFF  = 2'd0;
  localparam logic [1:0] SLOW_MED  = 2'd1;
  localparam logic [1:0] SLOW_LONG = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FILL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_FILL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WAIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FILL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_WAIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT   = 3'd7;

  // Configuration reset values
  localparam logic [BYTES_W-1:0] RST_HIGH_FILL  = 22'd16384;
  localparam logic [BYTES_W-1:0] RST_LOW_FILL   = 22'd4096;
  localparam logic [TICKS_W-1:0] RST_HIGH_WAIT  = 24'd20000;
  localparam logic [TICKS_W-1:0] RST_LOW_WAIT   = 24'd100000;
  localparam logic [BYTES_W-1:0] RST_START_FILL = 22'd8192;
  localparam logic [TICKS_W-1:0] RST_START_WAIT = 24'd0;
  localparam logic [TICKS_W-1:0] RST_FLUSH_WAIT = 24'd500000;
  localparam logic [TICKS_W-1:0] RST_MIN_WAIT   = 24'd1000;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] in_handle;
    logic [SIZE_W-1:0]   in_size;
  } pbc_in_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] out_handle;
    logic [SIZE_W-1:0]   out_size;
    logic [1:0]          status_code;
    logic [TICKS_W-1:0]  wait_time;
    logic [BYTES_W-1:0]  fill_bytes;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_flushing;
  } pbc_out_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load_item;  // latch the input beat and read the descriptor store
    logic commit;     // apply the update and load the result register
  } pbc_ctrl_t;

  typedef enum logic {
    PH_IDLE,
    PH_EXEC
  } pbc_state_t;

endpackage

/* rtl/core/pbc_ctrl.sv */
module pbc_ctrl
  import pbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pbc_ctrl_t ctrl
);

  pbc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Result register can take a new beat when empty or draining now
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE: begin
        if (in_valid) state_nxt = PH_EXEC;
      end
      PH_EXEC: begin
        if (out_free) state_nxt = PH_IDLE;
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall       = 1'b1;
    ctrl.load_item = 1'b0;
    ctrl.commit    = 1'b0;
    unique case (state_r)
      PH_IDLE: begin
        in_stall       = 1'b0;
        ctrl.load_item = in_valid;
      end
      PH_EXEC: begin
        ctrl.commit = out_free;
      end
      default: ;
    endcase
  end

  // Result valid: set on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/pbc_dpath.sv */
module pbc_dpath
  import pbc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pbc_ctrl_t            ctrl,
  input  pbc_in_t              in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data,
  output pbc_out_t             out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] nxt_ptr(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) r = '0;
    else r = p + AW'(1);
    return r;
  endfunction

  // Configuration registers
  logic [BYTES_W-1:0] high_fill_r, low_fill_r, start_fill_r;
  logic [TICKS_W-1:0] high_wait_r, low_wait_r, start_wait_r, flush_wait_r, min_wait_r;

  // Descriptor store
  logic [HANDLE_W+SIZE_W-1:0] desc_mem [DEPTH];
  logic [HANDLE_W+SIZE_W-1:0] rd_q_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;

  // Latched item
  pbc_in_t item_r;

  // Queue and release state
  logic [AW-1:0]      head_r, head_nxt, tail_r, tail_nxt, cursor_r, cursor_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic               cursor_ok_r, cursor_ok_nxt;
  logic               started_r, started_nxt;
  logic               done_r, done_nxt;
  logic               ready_r, ready_nxt;
  logic [1:0]         slow_r, slow_nxt;
  logic               flush_r, flush_nxt;
  logic [TICKS_W-1:0] since_push_r, since_push_nxt;
  logic [TICKS_W-1:0] since_pop_r, since_pop_nxt;
  logic [TICKS_W-1:0] since_start_r, since_start_nxt;

  pbc_out_t           res;
  pbc_out_t           out_q_r;
  logic [BYTES_W:0]   push_sum;
  logic               full;
  logic [TICKS_W-1:0] slow_to;
  logic [HANDLE_W-1:0] rd_handle;
  logic [SIZE_W-1:0]   rd_size;

  assign rd_handle = rd_q_r[HANDLE_W+SIZE_W-1:SIZE_W];
  assign rd_size   = rd_q_r[SIZE_W-1:0];
  assign full      = (count_r == CW'(DEPTH));
  assign push_sum  = {1'b0, total_r} + (BYTES_W+1)'(item_r.in_size);
  assign slow_to   = (slow_r == SLOW_LONG) ? low_wait_r : high_wait_r;

  // Read at head for pop, at cursor otherwise
  assign rd_addr = (in_data.cmd == CMD_POP) ? head_r : cursor_r;

  // Descriptor store: write on committed push, registered read on item load
  always_ff @(posedge clk) begin
    if (wr_en) desc_mem[tail_r] <= {item_r.in_handle, item_r.in_size};
    if (ctrl.load_item) rd_q_r <= desc_mem[rd_addr];
  end

  // Latch the input beat
  always_ff @(posedge clk) begin
    if (ctrl.load_item) item_r <= in_data;
  end

  // Execute the latched item
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cursor_nxt      = cursor_r;
    count_nxt       = count_r;
    total_nxt       = total_r;
    cursor_ok_nxt   = cursor_ok_r;
    started_nxt     = started_r;
    done_nxt        = done_r;
    ready_nxt       = ready_r;
    slow_nxt        = slow_r;
    flush_nxt       = flush_r;
    since_push_nxt  = since_push_r;
    since_pop_nxt   = since_pop_r;
    since_start_nxt = since_start_r;
    wr_en           = 1'b0;
    res             = '0;

    if (ctrl.commit) begin
      unique case (item_r.cmd)
        CMD_PUSH: begin
          if (!full && !push_sum[BYTES_W]) begin
            wr_en          = 1'b1;
            tail_nxt       = nxt_ptr(tail_r);
            count_nxt      = count_r + CW'(1);
            total_nxt      = push_sum[BYTES_W-1:0];
            flush_nxt      = 1'b0;
            since_push_nxt = '0;
            if (!started_r) begin
              started_nxt     = 1'b1;
              since_start_nxt = '0;
            end
            if (total_nxt >= high_fill_r) begin
              ready_nxt = 1'b1;
              slow_nxt  = SLOW_OFF;
            end
            if (!done_r) begin
              if (total_nxt >= start_fill_r) done_nxt = 1'b1;
              else if (started_nxt && start_wait_r != '0 &&
                       since_start_nxt >= start_wait_r) done_nxt = 1'b1;
            end
            res.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (count_r != '0) begin
            res.out_handle = rd_handle;
            res.out_size   = rd_size;
            if (cursor_ok_r && cursor_r == head_r) cursor_nxt = nxt_ptr(head_r);
            head_nxt      = nxt_ptr(head_r);
            count_nxt     = count_r - CW'(1);
            total_nxt     = total_r - BYTES_W'(rd_size);
            since_pop_nxt = '0;
            if (count_nxt == '0) cursor_ok_nxt = 1'b0;
            if (total_nxt < high_fill_r) begin
              ready_nxt = 1'b0;
              if (slow_r != SLOW_LONG) slow_nxt = SLOW_MED;
            end
            if (total_nxt < low_fill_r) slow_nxt = SLOW_LONG;
            res.ok = 1'b1;
          end
        end
        CMD_STATUS: begin
          res.ok = 1'b1;
          if (started_r && start_wait_r != '0 && since_start_r >= start_wait_r)
            done_nxt = 1'b1;
          if (!flush_r && done_nxt && since_push_r > flush_wait_r) flush_nxt = 1'b1;
          if (flush_nxt) begin
            res.status_code = (count_r != '0) ? STAT_READY : STAT_FLUSHED;
            res.wait_time   = min_wait_r;
          end else if (!done_nxt || count_r == '0) begin
            res.status_code = done_nxt ? STAT_NOT_READY : STAT_START_BUF;
            res.wait_time   = low_wait_r;
          end else if (ready_r) begin
            res.status_code = STAT_READY;
            res.wait_time   = min_wait_r;
          end else if (slow_r == SLOW_LONG || slow_r == SLOW_MED) begin
            if (since_pop_r >= slow_to) begin
              res.status_code = STAT_READY;
              res.wait_time   = min_wait_r;
            end else begin
              res.status_code = STAT_NOT_READY;
              res.wait_time   = slow_to - since_pop_r;
            end
          end else begin
            res.status_code = STAT_NOT_READY;
            res.wait_time   = '0;
          end
        end
        CMD_PARSE_START: begin
          if (count_r != '0) begin
            cursor_nxt    = head_r;
            cursor_ok_nxt = 1'b1;
            res.ok        = 1'b1;
          end
        end
        CMD_PARSE_NEXT: begin
          if (count_r != '0 && cursor_ok_r) begin
            res.out_handle = rd_handle;
            res.out_size   = rd_size;
            cursor_nxt     = nxt_ptr(cursor_r);
            if (cursor_nxt == tail_r) cursor_ok_nxt = 1'b0;
            res.ok = 1'b1;
          end
        end
        CMD_PARSE_STOP: begin
          cursor_ok_nxt = 1'b0;
          res.ok        = 1'b1;
        end
        CMD_TICK: begin
          if (since_push_r != '1) since_push_nxt = since_push_r + TICKS_W'(1);
          if (since_pop_r != '1) since_pop_nxt = since_pop_r + TICKS_W'(1);
          if (since_start_r != '1) since_start_nxt = since_start_r + TICKS_W'(1);
          res.ok = 1'b1;
        end
        default: ;
      endcase
      res.fill_bytes  = total_nxt;
      res.entry_count = COUNT_W'(count_nxt);
      res.is_flushing = flush_nxt;
    end
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      cursor_r      <= '0;
      count_r       <= '0;
      total_r       <= '0;
      cursor_ok_r   <= 1'b0;
      started_r     <= 1'b0;
      done_r        <= 1'b0;
      ready_r       <= 1'b0;
      slow_r        <= SLOW_LONG;
      flush_r       <= 1'b0;
      since_push_r  <= '0;
      since_pop_r   <= '0;
      since_start_r <= '0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      cursor_r      <= cursor_nxt;
      count_r       <= count_nxt;
      total_r       <= total_nxt;
      cursor_ok_r   <= cursor_ok_nxt;
      started_r     <= (cfg_we && cfg_index == CFG_START_WAIT) ? 1'b0 : started_nxt;
      done_r        <= done_nxt;
      ready_r       <= ready_nxt;
      slow_r        <= slow_nxt;
      flush_r       <= flush_nxt;
      since_push_r  <= since_push_nxt;
      since_pop_r   <= since_pop_nxt;
      since_start_r <= since_start_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_fill_r  <= RST_HIGH_FILL;
      low_fill_r   <= RST_LOW_FILL;
      high_wait_r  <= RST_HIGH_WAIT;
      low_wait_r   <= RST_LOW_WAIT;
      start_fill_r <= RST_START_FILL;
      start_wait_r <= RST_START_WAIT;
      flush_wait_r <= RST_FLUSH_WAIT;
      min_wait_r   <= RST_MIN_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_FILL:  high_fill_r  <= cfg_data[BYTES_W-1:0];
        CFG_LOW_FILL:   low_fill_r   <= cfg_data[BYTES_W-1:0];
        CFG_HIGH_WAIT:  high_wait_r  <= cfg_data;
        CFG_LOW_WAIT:   low_wait_r   <= cfg_data;
        CFG_START_FILL: start_fill_r <= cfg_data[BYTES_W-1:0];
        CFG_START_WAIT: start_wait_r <= cfg_data;
        CFG_FLUSH_WAIT: flush_wait_r <= cfg_data;
        CFG_MIN_WAIT:   min_wait_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.commit) out_q_r <= res;
  end

  assign out_data = out_q_r;

endmodule

/* rtl/core/playout_buffer_controller.sv */
// Release controller for a playout jitter buffer: a FIFO of message
// descriptors (handle, size) with a running byte total.
// Input channel (in_valid / in_stall / in_data): one beat per command
// (push, pop, status, parse start / next / stop, tick).
// Result channel (out_valid / out_stall / out_data): exactly one beat per
// command, in command order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; write only while no command is in flight.
// Sequencing: a command is taken in the idle state, and its result is registered
// in the execute state that follows unless the result register is full and
// stalled; no new command is taken before then. The execute state exists for
// the registered read of the descriptor memory used by pop and parse next.
// The next command is taken while a finished result still waits; when the
// receiver stalls with a result pending, the second command holds in its
// execute cycle and in_stall stays high until the result register drains.
// Reset (synchronous, rst_n low) empties the queue, loads the default
// thresholds and timeouts and clears all counters; no clearing pass.
module playout_buffer_controller
  import pbc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pbc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pbc_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data
);

  pbc_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  pbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  pbc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* sim/pbc_checker.sv */
module pbc_checker
  import pbc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  pbc_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  pbc_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  // Settings as the block holds them
  logic [BYTES_W-1:0] high_fill, low_fill, start_fill;
  logic [TICKS_W-1:0] high_wait, low_wait, start_wait, flush_wait, min_wait;

  // Descriptor queue and release state
  logic [HANDLE_W-1:0] handle_mem [DEPTH];
  logic [SIZE_W-1:0]   size_mem [DEPTH];
  logic [PTR_W-1:0]    head_ptr, tail_ptr, cursor_ptr;
  logic [COUNT_W-1:0]  entries;
  logic [BYTES_W-1:0]  bytes_held;
  logic                cursor_on, started, start_complete, ready, flushing;
  logic [1:0]          slow_sel;
  logic [TICKS_W-1:0]  since_push, since_pop, since_start;

  pbc_out_t owed_results [$];
  int       mismatches = 0;
  int       owed = 0;

  assign mismatch_count = mismatches;
  assign results_owed   = owed;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [TICKS_W-1:0] sat_tick(input logic [TICKS_W-1:0] v);
    return (v == '1) ? v : v + TICKS_W'(1);
  endfunction

  function automatic logic start_timeout_hit();
    return started && start_wait != '0 && since_start >= start_wait;
  endfunction

  task automatic clear_playout();
    high_fill  = RST_HIGH_FILL;
    low_fill   = RST_LOW_FILL;
    high_wait  = RST_HIGH_WAIT;
    low_wait   = RST_LOW_WAIT;
    start_fill = RST_START_FILL;
    start_wait = RST_START_WAIT;
    flush_wait = RST_FLUSH_WAIT;
    min_wait   = RST_MIN_WAIT;
    head_ptr = '0;
    tail_ptr = '0;
    cursor_ptr = '0;
    entries = '0;
    bytes_held = '0;
    cursor_on = 1'b0;
    started = 1'b0;
    start_complete = 1'b0;
    ready = 1'b0;
    slow_sel = SLOW_LONG;
    flushing = 1'b0;
    since_push = '0;
    since_pop = '0;
    since_start = '0;
    owed_results.delete();
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [TICKS_W-1:0] value);
    case (idx)
      CFG_HIGH_FILL:  high_fill = value[BYTES_W-1:0];
      CFG_LOW_FILL:   low_fill = value[BYTES_W-1:0];
      CFG_HIGH_WAIT:  high_wait = value;
      CFG_LOW_WAIT:   low_wait = value;
      CFG_START_FILL: start_fill = value[BYTES_W-1:0];
      CFG_START_WAIT: begin
        start_wait = value;
        started = 1'b0;
      end
      CFG_FLUSH_WAIT: flush_wait = value;
      CFG_MIN_WAIT:   min_wait = value;
      default: ;
    endcase
  endtask

  // Apply one command beat to the queue state and form its result
  task automatic advance_playout(input pbc_in_t beat, output pbc_out_t res);
    logic [BYTES_W:0]   sum;
    logic [TICKS_W-1:0] limit;
    res = '0;
    case (beat.cmd)
      CMD_PUSH: begin
        sum = {1'b0, bytes_held} + (BYTES_W+1)'(beat.in_size);
        // refuse on a full queue or a byte total past 22 bits
        if (entries < COUNT_W'(DEPTH) && !sum[BYTES_W]) begin
          handle_mem[tail_ptr] = beat.in_handle;
          size_mem[tail_ptr] = beat.in_size;
          tail_ptr = step_ptr(tail_ptr);
          entries++;
          bytes_held = sum[BYTES_W-1:0];
          flushing = 1'b0;
          since_push = '0;
          if (!started) begin
            started = 1'b1;
            since_start = '0;
          end
          if (bytes_held >= high_fill) begin
            ready = 1'b1;
            slow_sel = SLOW_OFF;
          end
          if (!start_complete) begin
            if (bytes_held >= start_fill) start_complete = 1'b1;
            else if (start_timeout_hit()) start_complete = 1'b1;
          end
          res.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (entries != '0) begin
          res.out_handle = handle_mem[head_ptr];
          res.out_size = size_mem[head_ptr];
          // drag the cursor along when it sits on the head
          if (cursor_on && cursor_ptr == head_ptr) cursor_ptr = step_ptr(head_ptr);
          head_ptr = step_ptr(head_ptr);
          entries--;
          bytes_held = bytes_held - BYTES_W'(res.out_size);
          since_pop = '0;
          if (entries == '0) cursor_on = 1'b0;
          if (bytes_held < high_fill) begin
            ready = 1'b0;
            if (slow_sel != SLOW_LONG) slow_sel = SLOW_MED;
          end
          if (bytes_held < low_fill) slow_sel = SLOW_LONG;
          res.ok = 1'b1;
        end
      end
      CMD_STATUS: begin
        res.ok = 1'b1;
        if (start_timeout_hit()) start_complete = 1'b1;
        if (!flushing && start_complete && since_push > flush_wait) flushing = 1'b1;
        if (flushing) begin
          res.status_code = (entries != '0) ? STAT_READY : STAT_FLUSHED;
          res.wait_time = min_wait;
        end else if (!start_complete || entries == '0) begin
          res.status_code = start_complete ? STAT_NOT_READY : STAT_START_BUF;
          res.wait_time = low_wait;
        end else if (ready) begin
          res.status_code = STAT_READY;
          res.wait_time = min_wait;
        end else if (slow_sel == SLOW_LONG || slow_sel == SLOW_MED) begin
          limit = (slow_sel == SLOW_LONG) ? low_wait : high_wait;
          if (since_pop >= limit) begin
            res.status_code = STAT_READY;
            res.wait_time = min_wait;
          end else begin
            res.status_code = STAT_NOT_READY;
            res.wait_time = limit - since_pop;
          end
        end else begin
          res.status_code = STAT_NOT_READY;
          res.wait_time = '0;
        end
      end
      CMD_PARSE_START: begin
        if (entries != '0) begin
          cursor_ptr = head_ptr;
          cursor_on = 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_PARSE_NEXT: begin
        if (entries != '0 && cursor_on) begin
          res.out_handle = handle_mem[cursor_ptr];
          res.out_size = size_mem[cursor_ptr];
          cursor_ptr = step_ptr(cursor_ptr);
          if (cursor_ptr == tail_ptr) cursor_on = 1'b0;
          res.ok = 1'b1;
        end
      end
      CMD_PARSE_STOP: begin
        cursor_on = 1'b0;
        res.ok = 1'b1;
      end
      CMD_TICK: begin
        since_push = sat_tick(since_push);
        since_pop = sat_tick(since_pop);
        since_start = sat_tick(since_start);
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.fill_bytes = bytes_held;
    res.entry_count = entries;
    res.is_flushing = flushing;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track every beat on the three channels
  always @(posedge clk) begin
    pbc_out_t want;
    if (!rst_n) begin
      clear_playout();
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        advance_playout(in_data, want);
        owed_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result beat expected none, got 0x%0h", $time, out_data);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_data.ok));
          check_field("out_handle", 32'(want.out_handle), 32'(out_data.out_handle));
          check_field("out_size", 32'(want.out_size), 32'(out_data.out_size));
          check_field("status_code", 32'(want.status_code), 32'(out_data.status_code));
          check_field("wait_time", 32'(want.wait_time), 32'(out_data.wait_time));
          check_field("fill_bytes", 32'(want.fill_bytes), 32'(out_data.fill_bytes));
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
          check_field("is_flushing", 32'(want.is_flushing), 32'(out_data.is_flushing));
        end
      end
    end
    owed = owed_results.size();
  end

endmodule

/* sim/tb_playout_buffer_controller.sv */
module tb_playout_buffer_controller;
  import pbc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pbc_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pbc_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICKS_W-1:0]   cfg_data = '0;

  int          mismatch_count;
  int          results_owed;
  int          sent = 0;
  bit          calm = 1'b0;
  int unsigned size_scale = 300;
  int          stall_left = 0;
  int          run_left = 0;

  playout_buffer_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pbc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stall the result channel in bursts, never in the calm tail
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      run_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 15);
        else run_left = $urandom_range(1, 30);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        run_left--;
      end
    end
  end

  // Present one command beat, with an occasional idle burst ahead of it
  task automatic send(input logic [CMD_W-1:0] op, input logic [HANDLE_W-1:0] h,
                      input logic [SIZE_W-1:0] sz);
    pbc_in_t beat;
    int      gap;
    logic    stalled;
    beat.cmd = op;
    beat.in_handle = h;
    beat.in_size = sz;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  // Wait until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic set_config(input logic [BYTES_W-1:0] hf, input logic [BYTES_W-1:0] lf,
                            input logic [TICKS_W-1:0] hw, input logic [TICKS_W-1:0] lw,
                            input logic [BYTES_W-1:0] sf, input logic [TICKS_W-1:0] sw,
                            input logic [TICKS_W-1:0] fw, input logic [TICKS_W-1:0] mw);
    cfg_beat(CFG_HIGH_FILL, TICKS_W'(hf));
    cfg_beat(CFG_LOW_FILL, TICKS_W'(lf));
    cfg_beat(CFG_HIGH_WAIT, hw);
    cfg_beat(CFG_LOW_WAIT, lw);
    cfg_beat(CFG_START_FILL, TICKS_W'(sf));
    cfg_beat(CFG_START_WAIT, sw);
    cfg_beat(CFG_FLUSH_WAIT, fw);
    cfg_beat(CFG_MIN_WAIT, mw);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, size_scale));
    endcase
  endfunction

  task automatic push_one();
    send(CMD_PUSH, HANDLE_W'($urandom), pick_size());
  endtask

  // One well-formed command sequence with random content
  task automatic run_sequence();
    int count;
    count = 0;
    case ($urandom_range(0, 9))
      0, 1: begin
        // fill, often past full
        count = $urandom_range(1, 70);
        repeat (count) begin
          push_one();
          if ($urandom_range(0, 7) == 0) send(CMD_STATUS, '0, '0);
        end
      end
      2, 3: begin
        // drain, often past empty
        count = $urandom_range(1, 70);
        repeat (count) begin
          send(CMD_POP, HANDLE_W'($urandom), '0);
          if ($urandom_range(0, 5) == 0) send(CMD_STATUS, '0, '0);
        end
      end
      4: begin
        // walk the queue with the cursor, popping now and then
        send(CMD_PARSE_START, '0, '0);
        count = $urandom_range(1, 12);
        repeat (count) begin
          if ($urandom_range(0, 5) == 0) send(CMD_POP, '0, '0);
          else send(CMD_PARSE_NEXT, '0, '0);
        end
        if ($urandom_range(0, 2) == 0) begin
          send(CMD_PARSE_STOP, '0, '0);
          send(CMD_PARSE_NEXT, '0, '0);
        end
      end
      5, 6: begin
        // let time pass and poll
        count = $urandom_range(1, 40);
        repeat (count) begin
          send(CMD_TICK, '0, '0);
          if ($urandom_range(0, 2) == 0) send(CMD_STATUS, '0, '0);
        end
      end
      7, 8: begin
        // noise: any command with any fields
        repeat (10) begin
          send(CMD_W'($urandom_range(0, 7)), HANDLE_W'($urandom),
               ($urandom_range(0, 1) == 0) ? pick_size() : SIZE_W'($urandom));
        end
      end
      default: begin
        // long silence, then see flushing begin and end
        count = $urandom_range(1, 110);
        repeat (count) send(CMD_TICK, '0, '0);
        send(CMD_STATUS, '0, '0);
        send(CMD_STATUS, '0, '0);
        push_one();
        send(CMD_STATUS, '0, '0);
      end
    endcase
  endtask

  initial begin : stimulus
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner commands under the reset settings
    send(CMD_STATUS, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_PARSE_START, '0, '0);
    send(CMD_PARSE_NEXT, '0, '0);
    send(CMD_PARSE_STOP, '0, '0);
    send(CMD_UNUSED, '1, '1);
    send(CMD_TICK, '0, '0);
    send(CMD_PUSH, '0, '0);
    send(CMD_PUSH, '1, '1);
    send(CMD_STATUS, '0, '0);
    send(CMD_PARSE_START, '0, '0);
    send(CMD_PARSE_NEXT, '0, '0);
    send(CMD_PARSE_NEXT, '0, '0);
    send(CMD_PARSE_NEXT, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_STATUS, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_PUSH, 16'h5555, 16'hAAAA);
    send(CMD_PUSH, 16'hAAAA, 16'h5555);
    send(CMD_PARSE_START, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_PARSE_NEXT, '0, '0);
    send(CMD_STATUS, '0, '0);

    // Random traffic across several settings
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin
          size_scale = 300;
          set_config(22'd2000, 22'd600, 24'd12, 24'd30, 22'd1000, 24'd8, 24'd40, 24'd3);
        end
        1: begin
          size_scale = 300;
          set_config('0, '0, '0, '0, '0, '0, '0, '0);
        end
        2: begin
          size_scale = 65535;
          set_config('1, '1, '1, '1, '1, '1, '1, '1);
        end
        default: begin
          size_scale = $urandom_range(50, 800);
          set_config(BYTES_W'($urandom_range(0, 4000)), BYTES_W'($urandom_range(0, 4000)),
                     TICKS_W'($urandom_range(0, 50)), TICKS_W'($urandom_range(0, 80)),
                     BYTES_W'($urandom_range(0, 4000)), TICKS_W'($urandom_range(0, 30)),
                     TICKS_W'($urandom_range(0, 100)), TICKS_W'($urandom));
        end
      endcase
      if (ph == 7) calm = 1'b1;
      target = sent + 200;
      while (sent < target) run_sequence();
    end

    drain_results();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
